// ----- rtl/core/bsds_pkg.sv -----
// Shared constants and types of the bitmap segment descriptor scanner.
package bsds_pkg;

  // Width of the running totals; they wrap at this many bits.
  localparam int unsigned TOTAL_WIDTH = 32;

  // Reset value of the inline zero-code limit.
  localparam logic [3:0] LIMIT_RESET = 4'd8;

  typedef logic [TOTAL_WIDTH-1:0] total_t;

  // One result beat as produced by the parser.
  typedef struct packed {
    logic [4:0]  seg_bytes;
    logic [31:0] zero_bytes;
    logic [31:0] seg_count;
    logic [31:0] seg_length_total;
    logic [31:0] desc_length_total;
    logic        stream_end;
    logic        truncated;
  } res_t;

endpackage

// ----- rtl/core/bitmap_segment_descriptor_scanner_unit.sv -----
// Top level of the bitmap segment descriptor scanner.
//
// Takes one descriptor-stream byte per beat and returns one result beat for
// every completed descriptor (segment length, zero-byte count and running
// totals of descriptors, segment bytes and canonical descriptor bytes), plus
// one beat flagged truncated when last_byte lands on an extended header or
// inside its extension bytes. Throughput is one byte per clock unless a
// result beat waits under out_stall: the parser state (phase, extension
// counters, zero accumulator, totals) is read and rewritten in the same
// cycle, so consecutive bytes chain without bubbles. An input beat passes
// through the input register, then the parser logic feeding the result
// register. Both registers advance together whenever the result register
// is empty or being taken; while a result beat waits under out_stall, the
// byte in the input register holds and in_stall rises until the result beat
// is taken. Write zero_compact_limit through cfg_we/cfg_data only while the
// block is idle; it resets to 8.
module bitmap_segment_descriptor_scanner_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  desc_byte,
  input  logic        first_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  seg_bytes,
  output logic [31:0] zero_bytes,
  output logic [31:0] seg_count,
  output logic [31:0] seg_length_total,
  output logic [31:0] desc_length_total,
  output logic        stream_end,
  output logic        truncated
);
  import bsds_pkg::*;

  logic [3:0] zero_compact_limit;

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_first;
  logic       s1_last;
  logic       s1_move;
  logic       in_take;

  // Parser outputs and result register.
  logic hit;
  res_t res;
  res_t out_res;

  // Advance the input register into the parser when the result slot frees.
  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_move;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_compact_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      zero_compact_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  // Payload: hold while stalled, load on a taken beat.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte  <= desc_byte;
      s1_first <= first_byte;
      s1_last  <= last_byte;
    end
  end

  bsds_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_move),
    .desc_byte (s1_byte),
    .first_byte(s1_first),
    .last_byte (s1_last),
    .limit     (zero_compact_limit),
    .hit       (hit),
    .res       (res)
  );

  // Result register: load on a producing byte, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move && hit) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && hit) begin
      out_res <= res;
    end
  end

  assign seg_bytes         = out_res.seg_bytes;
  assign zero_bytes        = out_res.zero_bytes;
  assign seg_count         = out_res.seg_count;
  assign seg_length_total  = out_res.seg_length_total;
  assign desc_length_total = out_res.desc_length_total;
  assign stream_end        = out_res.stream_end;
  assign truncated         = out_res.truncated;

endmodule

// ----- rtl/core/bsds_parser.sv -----
// Descriptor parser: phase state, zero-count accumulation and running totals.
module bsds_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic [7:0]     desc_byte,
  input  logic           first_byte,
  input  logic           last_byte,
  input  logic [3:0]     limit,
  output logic           hit,
  output bsds_pkg::res_t res
);
  import bsds_pkg::*;

  logic        in_extension, in_extension_next;
  logic [3:0]  ext_remaining, ext_remaining_next;
  logic [3:0]  ext_position, ext_position_next;
  logic [31:0] zero_accum, zero_accum_next;
  logic [4:0]  pending_seg_len, pending_seg_len_next;
  total_t      count_total, count_total_next;
  total_t      seglen_total, seglen_total_next;
  total_t      desclen_total, desclen_total_next;

  logic        in_ext;
  total_t      count_base, seglen_base, desclen_base;
  logic [4:0]  hdr_seg;
  logic [3:0]  code;
  logic [3:0]  rem_dec;
  logic [31:0] byte_shifted;
  logic [31:0] acc_new;
  logic [2:0]  canon;

  // Canonical descriptor size: header plus minimal bytes of a long count.
  function automatic logic [2:0] canon_len(input logic [31:0] zeros, input logic [3:0] lim);
    logic [2:0] n;
    if (zeros <= {28'd0, lim}) n = 3'd1;
    else if (zeros[31:24] != 8'd0) n = 3'd5;
    else if (zeros[23:16] != 8'd0) n = 3'd4;
    else if (zeros[15:8] != 8'd0) n = 3'd3;
    else n = 3'd2;
    return n;
  endfunction

  always_comb begin
    // A stream start drops totals and any partial descriptor.
    in_ext       = in_extension && !first_byte;
    count_base   = first_byte ? '0 : count_total;
    seglen_base  = first_byte ? '0 : seglen_total;
    desclen_base = first_byte ? '0 : desclen_total;
    hdr_seg      = {1'b0, desc_byte[7:4]} + 5'd1;
    code         = desc_byte[3:0];
    rem_dec      = ext_remaining - 4'd1;
    byte_shifted = (ext_position < 4'd4) ?
                   ({24'd0, desc_byte} << {ext_position[1:0], 3'b000}) : 32'd0;
    acc_new      = zero_accum | byte_shifted;
  end

  always_comb begin
    in_extension_next    = in_ext;
    ext_remaining_next   = first_byte ? 4'd0 : ext_remaining;
    ext_position_next    = first_byte ? 4'd0 : ext_position;
    zero_accum_next      = first_byte ? 32'd0 : zero_accum;
    pending_seg_len_next = first_byte ? 5'd0 : pending_seg_len;
    count_total_next     = count_base;
    seglen_total_next    = seglen_base;
    desclen_total_next   = desclen_base;
    hit                  = 1'b0;
    canon                = 3'd1;
    res.seg_bytes        = 5'd0;
    res.zero_bytes       = 32'd0;
    res.stream_end       = last_byte;
    res.truncated        = 1'b0;

    if (!in_ext) begin
      if (code <= limit) begin
        // Compact header: count is inline.
        hit                = 1'b1;
        res.seg_bytes      = hdr_seg;
        res.zero_bytes     = {28'd0, code};
        count_total_next   = count_base + total_t'(1);
        seglen_total_next  = seglen_base + total_t'(hdr_seg);
        desclen_total_next = desclen_base + total_t'(canon);
      end else begin
        in_extension_next    = 1'b1;
        ext_remaining_next   = code - limit;
        ext_position_next    = 4'd0;
        zero_accum_next      = 32'd0;
        pending_seg_len_next = hdr_seg;
        if (last_byte) begin
          hit                = 1'b1;
          res.truncated      = 1'b1;
          in_extension_next  = 1'b0;
          ext_remaining_next = 4'd0;
        end
      end
    end else begin
      zero_accum_next    = acc_new;
      ext_position_next  = (ext_position == 4'hf) ? ext_position : ext_position + 4'd1;
      ext_remaining_next = rem_dec;
      if (rem_dec == 4'd0) begin
        // Final extension byte closes the descriptor.
        in_extension_next  = 1'b0;
        hit                = 1'b1;
        canon              = canon_len(acc_new, limit);
        res.seg_bytes      = pending_seg_len;
        res.zero_bytes     = acc_new;
        count_total_next   = count_base + total_t'(1);
        seglen_total_next  = seglen_base + total_t'(pending_seg_len);
        desclen_total_next = desclen_base + total_t'(canon);
      end else if (last_byte) begin
        hit                = 1'b1;
        res.truncated      = 1'b1;
        in_extension_next  = 1'b0;
        ext_remaining_next = 4'd0;
        ext_position_next  = 4'd0;
      end
    end

    res.seg_count         = 32'(count_total_next);
    res.seg_length_total  = 32'(seglen_total_next);
    res.desc_length_total = 32'(desclen_total_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_extension    <= 1'b0;
      ext_remaining   <= 4'd0;
      ext_position    <= 4'd0;
      zero_accum      <= 32'd0;
      pending_seg_len <= 5'd0;
      count_total     <= '0;
      seglen_total    <= '0;
      desclen_total   <= '0;
    end else if (step) begin
      in_extension    <= in_extension_next;
      ext_remaining   <= ext_remaining_next;
      ext_position    <= ext_position_next;
      zero_accum      <= zero_accum_next;
      pending_seg_len <= pending_seg_len_next;
      count_total     <= count_total_next;
      seglen_total    <= seglen_total_next;
      desclen_total   <= desclen_total_next;
    end
  end

endmodule

// ----- rtl/core/bsds_checker.sv -----
// Port-level checker for the descriptor scanner, bound to the top level.
module bsds_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [4:0]  seg_bytes,
  input logic [31:0] zero_bytes,
  input logic [31:0] seg_count,
  input logic        stream_end,
  input logic        truncated
);

  // A truncated beat closes the stream and carries no descriptor.
  a_trunc_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && truncated |-> stream_end && seg_bytes == 5'd0 && zero_bytes == 32'd0)
    else $error("truncated beat with descriptor data");

  // A completed descriptor always has a segment length of 1 to 16 bytes.
  a_seg_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !truncated |-> seg_bytes != 5'd0 && seg_bytes <= 5'd16)
    else $error("segment length out of range");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(seg_count) && $stable(truncated))
    else $error("stalled result beat changed");

  // Input backpressure only comes from a result beat that is waiting.
  a_in_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |-> out_valid && out_stall)
    else $error("input stalled with the result side free");

  // No result beat directly after reset.
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result beat right after reset");

endmodule

bind bitmap_segment_descriptor_scanner_unit bsds_checker u_bsds_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .seg_bytes (seg_bytes),
  .zero_bytes(zero_bytes),
  .seg_count (seg_count),
  .stream_end(stream_end),
  .truncated (truncated)
);
